/* rtl/core/btpc_pkg.sv */
// Package for the barometric compensation pipeline: payload structs,
// register indexes and pipeline constants. No dependencies.
`default_nettype none
package btpc_pkg;
   localparam int unsigned DivSteps = 64;
   localparam logic [1:0] RegTempCalib  = 2'd0;
   localparam logic [1:0] RegPressCalibA = 2'd1;
   localparam logic [1:0] RegPressCalibB = 2'd2;
   localparam logic [1:0] RegPressCalibC = 2'd3;

   typedef struct packed {
      logic [19:0] adc_temp;
      logic [19:0] adc_press;
   } req_type;

   typedef struct packed {
      logic signed [31:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic               pressure_invalid;
   } rsp_type;
endpackage
`default_nettype wire

/* rtl/core/baro_temp_pressure_compensation.sv */
// Barometric temperature and pressure compensation, top level.
// Depends on btpc_pkg.
//
// Usage: write the four calibration registers through csr_ (index 0 the
// temperature words, 1..3 the pressure words) while the block is idle. Offer
// raw conversion pairs on req_; each transaction yields one result on rsp_.
// Throughput: one transaction per cycle while the receiver takes each result.
// Depth: 80 register stages; the last of them drives rsp_valid.
// The depth is set by the signed divider, unrolled into one restoring step
// per stage (64 stages), plus eight stages of products and one magnitude
// stage ahead of it, and six stages and the output register after it.
// Each multiply is kept near 32x32 (or 64x17) before a register; the 64-bit
// square after the divider is built from partial products over two stages.
// Reset clears every valid bit and the calibration registers; payload
// registers are not reset.
// When the receiver stalls, the whole pipeline holds; req_ready falls only
// while the output stage is full and not being taken.
`default_nettype none
module baro_temp_pressure_compensation (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire btpc_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output btpc_pkg::rsp_type    rsp_data,
   input  wire logic            csr_write,
   input  wire logic [1:0]      csr_index,
   input  wire logic [63:0]     csr_data
);
   import btpc_pkg::*;

   localparam int unsigned NDiv = DivSteps;

   logic [47:0] temp_calib_ff;
   logic [63:0] press_a_ff, press_b_ff;
   logic [15:0] press_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_calib_ff <= '0;
         press_a_ff <= '0;
         press_b_ff <= '0;
         press_c_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            RegTempCalib:   temp_calib_ff <= csr_data[47:0];
            RegPressCalibA: press_a_ff <= csr_data;
            RegPressCalibB: press_b_ff <= csr_data;
            RegPressCalibC: press_c_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   logic signed [16:0] t1;
   logic signed [15:0] t2, t3;
   logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
   assign t1 = {1'b0, temp_calib_ff[15:0]};
   assign t2 = temp_calib_ff[31:16];
   assign t3 = temp_calib_ff[47:32];
   assign p1 = {48'd0, press_a_ff[15:0]};
   assign p2 = {{48{press_a_ff[31]}}, press_a_ff[31:16]};
   assign p3 = {{48{press_a_ff[47]}}, press_a_ff[47:32]};
   assign p4 = {{48{press_a_ff[63]}}, press_a_ff[63:48]};
   assign p5 = {{48{press_b_ff[15]}}, press_b_ff[15:0]};
   assign p6 = {{48{press_b_ff[31]}}, press_b_ff[31:16]};
   assign p7 = {{48{press_b_ff[47]}}, press_b_ff[47:32]};
   assign p8 = {{48{press_b_ff[63]}}, press_b_ff[63:48]};
   assign p9 = {{48{press_c_ff[15]}}, press_c_ff[15:0]};

   // One shared enable: every stage advances unless the output is blocked.
   logic advance;
   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // 64x64 low product over two stages: low*low, then cross terms.
   // Stage helpers are written inline per stage.

   // ---------------- stage 1: temperature differences, raw pressure
   logic        v1_ff;
   logic signed [18:0] d1_ff, d2_ff;
   logic [19:0] ap1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (advance) v1_ff <= req_valid;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         d1_ff  <= $signed({2'b0, req_data.adc_temp[19:3]}) - (19'(t1) <<< 1);
         d2_ff  <= $signed({3'b0, req_data.adc_temp[19:4]}) - 19'(t1);
         ap1_ff <= req_data.adc_press;
      end
   end

   // ---------------- stage 2: d1*t2, d2*d2
   logic        v2_ff;
   logic signed [34:0] m1_ff;
   logic signed [37:0] sq2_ff;
   logic [19:0] ap2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (advance) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         m1_ff  <= 35'(d1_ff * t2);
         sq2_ff <= 38'(d2_ff * d2_ff);
         ap2_ff <= ap1_ff;
      end
   end

   // ---------------- stage 3: (sq>>12)*t3
   logic        v3_ff;
   logic signed [23:0] var1_ff;
   logic signed [41:0] m2_ff;
   logic [19:0] ap3_ff;
   logic signed [25:0] sq_s;
   assign sq_s = 26'(sq2_ff >>> 12);
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (advance) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         var1_ff <= 24'(m1_ff >>> 11);
         m2_ff   <= 42'(sq_s * t3);
         ap3_ff  <= ap2_ff;
      end
   end

   // ---------------- stage 4: t_fine, a = tf-128000
   logic        v4_ff;
   logic signed [31:0] tf4_ff;
   logic signed [63:0] a4_ff;
   logic [19:0] ap4_ff;
   logic signed [31:0] tf_s;
   assign tf_s = 32'(32'(var1_ff) + 32'(m2_ff >>> 14));
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (advance) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         tf4_ff <= tf_s;
         a4_ff  <= 64'(tf_s) - 64'sd128000;
         ap4_ff <= ap3_ff;
      end
   end

   // a fits in 34 signed bits, so a*a fits in 67; all products here are
   // taken modulo 2^64 and split so each multiply stays near 32x32.
   // ---------------- stage 5: a*a (34x34), a*p5, a*p2
   logic        v5_ff;
   logic signed [31:0] tf5_ff;
   logic [63:0] aa5_ff, ap5m_ff, ap2m_ff;
   logic [19:0] ap5_ff;
   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else if (advance) v5_ff <= v4_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         aa5_ff  <= 64'($signed(a4_ff[33:0]) * $signed(a4_ff[33:0]));
         ap5m_ff <= 64'(a4_ff * $signed(p5[16:0]));
         ap2m_ff <= 64'(a4_ff * $signed(p2[16:0]));
         tf5_ff  <= tf4_ff;
         ap5_ff  <= ap4_ff;
      end
   end
   // note: aa is the low 64 bits of a*a, exact mod 2^64.

   // ---------------- stage 6: aa*p6, aa*p3 (64x17, low 64)
   logic        v6_ff;
   logic signed [31:0] tf6_ff;
   logic [63:0] b6_ff, ca6_ff, ap2c_ff;
   logic [19:0] ap6_ff;
   always_ff @(posedge clock) begin
      if (reset) v6_ff <= 1'b0;
      else if (advance) v6_ff <= v5_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b6_ff   <= 64'($signed(aa5_ff) * $signed(p6[16:0])) + (ap5m_ff << 17)
                    + (p4 << 35);
         ca6_ff  <= 64'($signed(aa5_ff) * $signed(p3[16:0]));
         ap2c_ff <= ap2m_ff << 12;
         tf6_ff  <= tf5_ff;
         ap6_ff  <= ap5_ff;
      end
   end

   // ---------------- stage 7: (ca>>8) + ap2c + 2^47; the p1 product and >>33 follow in stage 8
   logic        v7_ff;
   logic signed [31:0] tf7_ff;
   logic [63:0] b7_ff, sa7_ff;
   logic [19:0] ap7_ff;
   always_ff @(posedge clock) begin
      if (reset) v7_ff <= 1'b0;
      else if (advance) v7_ff <= v6_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         sa7_ff <= 64'($signed(ca6_ff) >>> 8) + ap2c_ff + (64'd1 << 47);
         b7_ff  <= b6_ff;
         tf7_ff <= tf6_ff;
         ap7_ff <= ap6_ff;
      end
   end

   // ---------------- stage 8: divisor and numerator
   logic        v8_ff;
   logic signed [31:0] tf8_ff;
   logic [63:0] den8_ff, num8_ff;
   logic [63:0] am_s, nb_s;
   assign am_s = 64'(sa7_ff * p1[15:0]);
   assign nb_s = ((64'd1048576 - 64'(ap7_ff)) << 31) - b7_ff;
   always_ff @(posedge clock) begin
      if (reset) v8_ff <= 1'b0;
      else if (advance) v8_ff <= v7_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         den8_ff <= 64'($signed(am_s) >>> 33);
         num8_ff <= 64'(nb_s * 64'd3125);
         tf8_ff  <= tf7_ff;
      end
   end

   // ---------------- divider: magnitudes, then one restoring step a stage
   logic        dv_ff [NDiv+1];
   logic [63:0] rem_ff [NDiv+1];
   logic [63:0] quo_ff [NDiv+1];
   logic [63:0] dsr_ff [NDiv+1];
   logic        neg_ff [NDiv+1];
   logic        zero_ff [NDiv+1];
   logic signed [31:0] tfd_ff [NDiv+1];

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (advance) dv_ff[0] <= v8_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         quo_ff[0]  <= num8_ff[63] ? 64'(0 - num8_ff) : num8_ff;
         dsr_ff[0]  <= den8_ff[63] ? 64'(0 - den8_ff) : den8_ff;
         neg_ff[0]  <= num8_ff[63] ^ den8_ff[63];
         zero_ff[0] <= den8_ff == '0;
         tfd_ff[0]  <= tf8_ff;
      end
   end

   for (genvar i = 0; i < NDiv; i++) begin : g_div
      logic [64:0] trial;
      logic [64:0] shifted;
      assign shifted = {rem_ff[i], quo_ff[i][63]};
      assign trial = shifted - {1'b0, dsr_ff[i]};
      always_ff @(posedge clock) begin
         if (reset) dv_ff[i+1] <= 1'b0;
         else if (advance) dv_ff[i+1] <= dv_ff[i];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[i+1]  <= trial[64] ? shifted[63:0] : trial[63:0];
            quo_ff[i+1]  <= {quo_ff[i][62:0], !trial[64]};
            dsr_ff[i+1]  <= dsr_ff[i];
            neg_ff[i+1]  <= neg_ff[i];
            zero_ff[i+1] <= zero_ff[i];
            tfd_ff[i+1]  <= tfd_ff[i];
         end
      end
   end

   // ---------------- post 1: sign the quotient
   logic        w1_ff, z1_ff;
   logic signed [31:0] tw1_ff;
   logic [63:0] q1_ff;
   always_ff @(posedge clock) begin
      if (reset) w1_ff <= 1'b0;
      else if (advance) w1_ff <= dv_ff[NDiv];
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         q1_ff  <= neg_ff[NDiv] ? 64'(0 - quo_ff[NDiv]) : quo_ff[NDiv];
         z1_ff  <= zero_ff[NDiv];
         tw1_ff <= tfd_ff[NDiv];
      end
   end

   // ---------------- post 2: ps = p>>13; ps*ps split: lo x lo, lo x hi partials
   logic        w2_ff, z2_ff;
   logic signed [31:0] tw2_ff;
   logic [63:0] q2_ff, pll_ff, plh_ff, c2m_ff;
   logic [63:0] ps_s;
   assign ps_s = 64'($signed(q1_ff) >>> 13);
   always_ff @(posedge clock) begin
      if (reset) w2_ff <= 1'b0;
      else if (advance) w2_ff <= w1_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         pll_ff <= 64'(ps_s[31:0] * ps_s[31:0]);
         plh_ff <= 64'(ps_s[31:0] * ps_s[63:32]);
         c2m_ff <= 64'($signed(q1_ff) * $signed(p8[16:0]));
         q2_ff  <= q1_ff;
         z2_ff  <= z1_ff;
         tw2_ff <= tw1_ff;
      end
   end

   // ---------------- post 3: ps*ps mod 2^64
   logic        w3_ff, z3_ff;
   logic signed [31:0] tw3_ff;
   logic [63:0] q3_ff, pp3_ff, c2_ff;
   always_ff @(posedge clock) begin
      if (reset) w3_ff <= 1'b0;
      else if (advance) w3_ff <= w2_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         pp3_ff <= pll_ff + {plh_ff[30:0], 33'd0};
         c2_ff  <= 64'($signed(c2m_ff) >>> 19);
         q3_ff  <= q2_ff;
         z3_ff  <= z2_ff;
         tw3_ff <= tw2_ff;
      end
   end

   // ---------------- post 4: p9*ps*ps (64x17 split in two halves)
   logic        w4_ff, z4_ff;
   logic signed [31:0] tw4_ff;
   logic [63:0] q4_ff, c2b_ff, m9l_ff, m9h_ff;
   always_ff @(posedge clock) begin
      if (reset) w4_ff <= 1'b0;
      else if (advance) w4_ff <= w3_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         // low half is unsigned, p9 keeps its sign
         m9l_ff <= 64'($signed({1'b0, pp3_ff[31:0]}) * $signed(p9[16:0]));
         m9h_ff <= 64'(pp3_ff[63:32] * p9[31:0]);
         c2b_ff <= c2_ff;
         q4_ff  <= q3_ff;
         z4_ff  <= z3_ff;
         tw4_ff <= tw3_ff;
      end
   end

   // ---------------- post 5: combine c1 partials
   logic        w5_ff, z5_ff;
   logic signed [31:0] tw5_ff;
   logic [63:0] q5_ff, c2c_ff, c1m_ff;
   always_ff @(posedge clock) begin
      if (reset) w5_ff <= 1'b0;
      else if (advance) w5_ff <= w4_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         c1m_ff <= m9l_ff + {m9h_ff[31:0], 32'd0};
         c2c_ff <= c2b_ff;
         q5_ff  <= q4_ff;
         z5_ff  <= z4_ff;
         tw5_ff <= tw4_ff;
      end
   end

   // ---------------- post 6: sum of p, c1 = c1m>>25 and c2
   logic        w6_ff, z6_ff;
   logic signed [31:0] tw6_ff;
   logic [63:0] s6_ff;
   always_ff @(posedge clock) begin
      if (reset) w6_ff <= 1'b0;
      else if (advance) w6_ff <= w5_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         s6_ff  <= q5_ff + 64'($signed(c1m_ff) >>> 25) + c2c_ff;
         z6_ff  <= z5_ff;
         tw6_ff <= tw5_ff;
      end
   end

   // ---------------- output register
   logic    out_v_ff;
   rsp_type out_ff;
   logic [63:0] pres_s;
   logic [35:0] tmp_s;
   assign pres_s = 64'($signed(s6_ff) >>> 8) + (p7 << 4);
   assign tmp_s  = 36'(($signed({{4{tw6_ff[31]}}, tw6_ff}) * 36'sd5 + 36'sd128) >>> 8);
   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (advance) out_v_ff <= w6_ff;
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff.temperature_centi <= tmp_s[31:0];
         out_ff.pressure_q24_8    <= z6_ff ? 32'd0 : pres_s[31:0];
         out_ff.pressure_invalid  <= z6_ff;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;
endmodule
`default_nettype wire

/* tb/sv/baro_temp_pressure_compensation_check.sv */
// Checker for the barometric compensation block: watches the req_, rsp_ and
// csr_ ports, predicts each result and compares it field by field.
// Depends on btpc_pkg.
`timescale 1ns / 100ps
module baro_temp_pressure_compensation_check (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire btpc_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire btpc_pkg::rsp_type rsp_data,
   input  wire logic              csr_write,
   input  wire logic [1:0]        csr_index,
   input  wire logic [63:0]       csr_data,
   output int unsigned            fail_count,
   output int unsigned            pending_count
);
   import btpc_pkg::*;

   logic [47:0] cal_temp;
   logic [63:0] cal_press_a;
   logic [63:0] cal_press_b;
   logic [15:0] cal_press_c;
   rsp_type     expected_q[$];

   function automatic longint ext16(input logic [15:0] w);
      return longint'({{48{w[15]}}, w});
   endfunction

   // truncating signed divide, most negative by minus one wraps to itself
   function automatic longint div_trunc(input longint n, input longint d);
      logic [63:0] mn;
      logic [63:0] md;
      logic [63:0] q;
      mn = n[63] ? -n : n;
      md = d[63] ? -d : d;
      q  = mn / md;
      return (n[63] != d[63]) ? longint'(-q) : longint'(q);
   endfunction

   function automatic rsp_type compensate(input req_type item);
      longint at, ap, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
      longint d1, v1, d2, sq, v2, tf, a, b, p, ps, c1, c2;
      logic [31:0] tf32;
      rsp_type r;
      at = longint'({44'd0, item.adc_temp});
      ap = longint'({44'd0, item.adc_press});
      t1 = longint'({48'd0, cal_temp[15:0]});
      t2 = ext16(cal_temp[31:16]);
      t3 = ext16(cal_temp[47:32]);
      p1 = longint'({48'd0, cal_press_a[15:0]});
      p2 = ext16(cal_press_a[31:16]);
      p3 = ext16(cal_press_a[47:32]);
      p4 = ext16(cal_press_a[63:48]);
      p5 = ext16(cal_press_b[15:0]);
      p6 = ext16(cal_press_b[31:16]);
      p7 = ext16(cal_press_b[47:32]);
      p8 = ext16(cal_press_b[63:48]);
      p9 = ext16(cal_press_c);

      d1 = (at >>> 3) - t1 * 2;
      v1 = (d1 * t2) >>> 11;
      d2 = (at >>> 4) - t1;
      sq = (d2 * d2) >>> 12;
      v2 = (sq * t3) >>> 14;
      tf32 = 32'(v1 + v2);
      tf = longint'({{32{tf32[31]}}, tf32});
      r.temperature_centi = 32'((tf * 5 + 128) >>> 8);

      a = tf - 128000;
      b = a * a * p6;
      b = b + ((a * p5) <<< 17);
      b = b + (p4 <<< 35);
      a = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
      a = (((longint'(1) <<< 47) + a) * p1) >>> 33;
      if (a == 0) begin
         r.pressure_q24_8 = '0;
         r.pressure_invalid = 1'b1;
      end else begin
         p = 1048576 - ap;
         p = div_trunc(((p <<< 31) - b) * 3125, a);
         ps = p >>> 13;
         c1 = (p9 * ps * ps) >>> 25;
         c2 = (p8 * p) >>> 19;
         p = ((p + c1 + c2) >>> 8) + (p7 <<< 4);
         r.pressure_q24_8 = 32'(p);
         r.pressure_invalid = 1'b0;
      end
      return r;
   endfunction

   assign pending_count = expected_q.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         cal_temp    <= '0;
         cal_press_a <= '0;
         cal_press_b <= '0;
         cal_press_c <= '0;
         fail_count  <= 0;
         expected_q.delete();
      end else begin
         if (req_valid && req_ready)
            expected_q.push_back(compensate(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               $error("unexpected transaction on rsp_");
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_data !== want) begin
                  fail_count <= fail_count + 1;
                  if (rsp_data.temperature_centi !== want.temperature_centi)
                     $error("temperature_centi: expected %0d, actual %0d",
                            want.temperature_centi, rsp_data.temperature_centi);
                  if (rsp_data.pressure_q24_8 !== want.pressure_q24_8)
                     $error("pressure_q24_8: expected %h, actual %h",
                            want.pressure_q24_8, rsp_data.pressure_q24_8);
                  if (rsp_data.pressure_invalid !== want.pressure_invalid)
                     $error("pressure_invalid: expected %b, actual %b",
                            want.pressure_invalid, rsp_data.pressure_invalid);
               end
            end
         end
         if (csr_write) begin
            case (csr_index)
               RegTempCalib:   cal_temp    <= csr_data[47:0];
               RegPressCalibA: cal_press_a <= csr_data;
               RegPressCalibB: cal_press_b <= csr_data;
               RegPressCalibC: cal_press_c <= csr_data[15:0];
               default: ;
            endcase
         end
      end
   end
endmodule

/* tb/sv/baro_temp_pressure_compensation_test.sv */
// Top of the compensation testbench: clock, reset, calibration phases and
// raw sample stimulus with random idling. Depends on btpc_pkg, the block
// and baro_temp_pressure_compensation_check.
`timescale 1ns / 100ps
module baro_temp_pressure_compensation_test;
   import btpc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_write = 1'b0;
   logic [1:0]  csr_index = RegTempCalib;
   logic [63:0] csr_data = '0;
   int unsigned fail_count;
   int unsigned pending_count;
   bit          quiet = 1'b0;
   int          stall_left = 0;
   int          run_left = 0;

   baro_temp_pressure_compensation dut (.*);
   baro_temp_pressure_compensation_check checker_inst (.*);

   always #2 clock = ~clock;

   // receiver: bursts of back-pressure between runs of readiness
   always @(negedge clock) begin
      if (quiet || reset) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (run_left > 0) begin
         rsp_ready <= 1'b1;
         run_left--;
      end else begin
         stall_left = $urandom_range(1, 6) - 1;
         run_left = $urandom_range(0, 14);
         rsp_ready <= 1'b0;
      end
   end

   task automatic write_calib(input logic [1:0] idx, input logic [63:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic load_calib(input logic [63:0] t, input logic [63:0] pa,
                             input logic [63:0] pb, input logic [63:0] pc);
      write_calib(RegTempCalib, t);
      write_calib(RegPressCalibA, pa);
      write_calib(RegPressCalibB, pb);
      write_calib(RegPressCalibC, pc);
   endtask

   task automatic send_sample(input logic [19:0] at, input logic [19:0] ap);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= '{adc_temp: at, adc_press: ap};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // hold the sender until every result is back, then let the pipe empty
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [19:0] raw_value;
      case ($urandom_range(0, 7))
         0: return 20'h00000;
         1: return 20'hFFFFF;
         default: return 20'($urandom);
      endcase
   endfunction

   task automatic random_samples(input int count);
      repeat (count) send_sample(raw_value(), raw_value());
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset calibration: divisor is zero, pressure flagged invalid
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hFFFFF, 20'hFFFFF);
      drain();

      // typical sensor calibration, directed corners
      load_calib({16'hFC18, 16'h6743, 16'h6B70},
                 {16'h0B27, 16'h0BD0, 16'hD641, 16'h8E7D},
                 {16'hC6F8, 16'h3C8C, 16'hFFF9, 16'h008C},
                 64'(16'h1770));
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hFFFFF, 20'hFFFFF);
      send_sample(20'h00000, 20'hFFFFF);
      send_sample(20'hFFFFF, 20'h00000);
      send_sample(20'h7EED0, 20'h65A00);
      send_sample(20'h80000, 20'h80000);
      send_sample(20'h7FFFF, 20'h7FFFF);
      send_sample(20'hD6C00, 20'h00001);
      random_samples(200);
      drain();

      // P1 at its smallest nonzero value, all other calibration words zero
      load_calib({16'h0000, 16'h0000, 16'h0000},
                 {16'h0000, 16'h0000, 16'h0000, 16'h0001},
                 64'h0, 64'h0);
      send_sample(20'h00000, 20'h12345);
      send_sample(20'hFFFFF, 20'hFFFFF);
      drain();

      // every word at its most negative or largest value
      load_calib({16'h8000, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
                 {16'h8000, 16'h8000, 16'h8000, 16'h8000},
                 64'(16'h8000));
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hFFFFF, 20'hFFFFF);
      random_samples(150);
      drain();

      load_calib({16'h7FFF, 16'h7FFF, 16'h0000},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
                 {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
                 64'(16'h7FFF));
      send_sample(20'h00000, 20'h00000);
      send_sample(20'hFFFFF, 20'hFFFFF);
      random_samples(150);
      drain();

      // all ones, including bits above each register's width
      load_calib('1, '1, '1, '1);
      random_samples(150);
      drain();

      repeat (4) begin
         load_calib({$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, $urandom});
         random_samples(150);
         drain();
      end

      // closing stretch without idling on either side
      quiet = 1'b1;
      load_calib({16'hFC18, 16'h6743, 16'h6B70},
                 {$urandom, $urandom}, {$urandom, $urandom}, 64'($urandom));
      random_samples(100);
      drain();

      if (fail_count == 0 && pending_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("end of test: mismatches");
      $finish;
   end
endmodule

/* sim.f */
rtl/core/btpc_pkg.sv
rtl/core/baro_temp_pressure_compensation.sv
tb/sv/baro_temp_pressure_compensation_check.sv
tb/sv/baro_temp_pressure_compensation_test.sv
